/* sv/indexed_pixel_to_mono_bitmap_macros.svh */
// assertion macros for the indexed pixel to mono bitmap block
`ifndef INDEXED_PIXEL_TO_MONO_BITMAP_MACROS_SVH
`define INDEXED_PIXEL_TO_MONO_BITMAP_MACROS_SVH

// same-cycle implication, disabled during reset
`define IPMB_ASSERT_SAME(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ipmb same-cycle check failed");

// next-cycle implication, disabled during reset
`define IPMB_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ipmb next-cycle check failed");

`endif

/* sv/ipmb_pkg.sv */
// shared types, codes and constants of the indexed pixel to mono bitmap block
package ipmb_pkg;

  // screen and palette defaults
  localparam int SCREEN_WIDTH  = 1280;
  localparam int PALETTE_DEPTH = 256;

  // field widths
  localparam int IDX_W    = 8;
  localparam int COL_W    = 11;
  localparam int ROW_W    = 10;
  localparam int PITCH_W  = 11;
  localparam int PCNT_W   = 9;
  localparam int ADDR_W   = 20;
  localparam int MASK_W   = 8;
  localparam int LUMA_W   = 18;
  localparam int SX_W     = COL_W + 1;
  localparam int SY_W     = ROW_W + 1;

  // luma weights and white threshold
  localparam logic [LUMA_W-1:0] LUMA_R     = 18'd299;
  localparam logic [LUMA_W-1:0] LUMA_G     = 18'd587;
  localparam logic [LUMA_W-1:0] LUMA_B     = 18'd114;
  localparam logic [LUMA_W-1:0] LUMA_LIMIT = 18'd128000;

  localparam logic [MASK_W-1:0] MASK_MSB = 8'h80;

  // input modes
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_PIXEL = 2'd1;
  localparam logic [1:0] MODE_FRAME = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_NONE  = 2'd0;
  localparam logic [1:0] STATUS_WRITE = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  // work codes passed from front to back
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_ERROR = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEFT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TOP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSP_EN     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSP_INDEX  = 3'd6;

  // decoupling queue depth
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [COL_W-1:0]   frame_left;
    logic [ROW_W-1:0]   frame_top;
    logic [COL_W-1:0]   frame_width;
    logic [PITCH_W-1:0] line_pitch;
    logic [PCNT_W-1:0]  palette_count;
    logic               transparent_enable;
    logic [IDX_W-1:0]   transparent_index;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [IDX_W-1:0]  idx;
    logic              white;
    logic [ADDR_W-1:0] addr;
    logic [MASK_W-1:0] mask;
  } entry_t;

endpackage

/* sv/ipmb_ram.sv */
// generic single-write, single-read ram with registered read data
module ipmb_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port, holds when not read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/ipmb_front.sv */
// front end: accepts transactions, tracks raster position, classifies and computes address
module ipmb_front #(
  parameter int PALETTE_DEPTH = ipmb_pkg::PALETTE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ipmb_pkg::cfg_t                      cfg,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_mode,
  input  logic [ipmb_pkg::IDX_W-1:0]          in_color_index,
  input  logic [7:0]                          in_red,
  input  logic [7:0]                          in_green,
  input  logic [7:0]                          in_blue,
  output logic                                q_push,
  output ipmb_pkg::entry_t                    q_entry,
  input  logic                                q_full
);

  localparam logic [ipmb_pkg::PCNT_W-1:0] DEPTH_N = ipmb_pkg::PCNT_W'(PALETTE_DEPTH);
  localparam int PROD_W = ipmb_pkg::ADDR_W + 2;

  // stage a registers
  logic                                a_vld_r, a_vld_nxt;
  logic [1:0]                          a_op_r;
  logic [ipmb_pkg::IDX_W-1:0]          a_idx_r;
  logic [ipmb_pkg::SX_W-1:0]           a_sx_r;
  logic [ipmb_pkg::SY_W-1:0]           a_sy_r;
  logic [ipmb_pkg::LUMA_W-1:0]         a_pr_r, a_pg_r, a_pb_r;

  // stage b registers
  logic                                b_vld_r, b_vld_nxt;
  ipmb_pkg::entry_t                    b_entry_r;

  // raster counters
  logic [ipmb_pkg::COL_W-1:0]          col_r, col_nxt;
  logic [ipmb_pkg::ROW_W-1:0]          row_r, row_nxt;

  logic                                in_acc, a_go, b_go, b_free, a_free;
  logic                                transp, idx_ok, idx_err;
  logic [1:0]                          op_in;
  logic [ipmb_pkg::COL_W-1:0]          col_inc;
  logic [ipmb_pkg::SX_W-1:0]           sx_in;
  logic [ipmb_pkg::SY_W-1:0]           sy_in;
  logic [PROD_W-1:0]                   row_prod;
  logic [ipmb_pkg::ADDR_W-1:0]         addr_b;
  logic [ipmb_pkg::LUMA_W-1:0]         luma_b;
  ipmb_pkg::entry_t                    entry_b;

  // flow control through the two stages into the queue
  assign b_go     = b_vld_r && !q_full;
  assign b_free   = !b_vld_r || b_go;
  assign a_go     = a_vld_r && b_free;
  assign a_free   = !a_vld_r || a_go;
  assign in_stall = !a_free;
  assign in_acc   = in_valid && a_free;

  // classification of the incoming transaction
  assign transp  = cfg.transparent_enable && (in_color_index == cfg.transparent_index);
  assign idx_ok  = {1'b0, in_color_index} < DEPTH_N;
  assign idx_err = ({1'b0, in_color_index} >= cfg.palette_count) || !idx_ok;

  always_comb begin
    case (in_mode)
      ipmb_pkg::MODE_LOAD: begin
        op_in = idx_ok ? ipmb_pkg::OP_LOAD : ipmb_pkg::OP_NONE;
      end
      ipmb_pkg::MODE_PIXEL: begin
        if (transp) begin
          op_in = ipmb_pkg::OP_NONE;
        end else if (idx_err) begin
          op_in = ipmb_pkg::OP_ERROR;
        end else begin
          op_in = ipmb_pkg::OP_WRITE;
        end
      end
      default: begin
        op_in = ipmb_pkg::OP_NONE;
      end
    endcase
  end

  // screen position of the current raster point
  assign sx_in = {1'b0, cfg.frame_left} + {1'b0, col_r};
  assign sy_in = {1'b0, cfg.frame_top} + {1'b0, row_r};

  // raster advance on pixels, restart on start of frame
  assign col_inc = col_r + ipmb_pkg::COL_W'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      case (in_mode)
        ipmb_pkg::MODE_PIXEL: begin
          if (col_inc >= cfg.frame_width) begin
            col_nxt = '0;
            row_nxt = row_r + ipmb_pkg::ROW_W'(1);
          end else begin
            col_nxt = col_inc;
          end
        end
        ipmb_pkg::MODE_FRAME: begin
          col_nxt = '0;
          row_nxt = '0;
        end
        default: begin
          col_nxt = col_r;
        end
      endcase
    end
  end

  always_comb begin
    a_vld_nxt = a_vld_r;
    if (in_acc) begin
      a_vld_nxt = 1'b1;
    end else if (a_go) begin
      a_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    b_vld_nxt = b_vld_r;
    if (a_go) begin
      b_vld_nxt = 1'b1;
    end else if (b_go) begin
      b_vld_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      a_vld_r <= a_vld_nxt;
      b_vld_r <= b_vld_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  // stage a payload: luma partial products and screen position
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_op_r  <= op_in;
      a_idx_r <= in_color_index;
      a_sx_r  <= sx_in;
      a_sy_r  <= sy_in;
      a_pr_r  <= ipmb_pkg::LUMA_W'(in_red) * ipmb_pkg::LUMA_R;
      a_pg_r  <= ipmb_pkg::LUMA_W'(in_green) * ipmb_pkg::LUMA_G;
      a_pb_r  <= ipmb_pkg::LUMA_W'(in_blue) * ipmb_pkg::LUMA_B;
    end
  end

  // stage b: luma threshold, byte address and bit mask
  assign luma_b   = a_pr_r + a_pg_r + a_pb_r;
  assign row_prod = PROD_W'(a_sy_r) * PROD_W'(cfg.line_pitch);
  assign addr_b   = row_prod[ipmb_pkg::ADDR_W-1:0]
                  + ipmb_pkg::ADDR_W'(a_sx_r[ipmb_pkg::SX_W-1:3]);

  always_comb begin
    entry_b.op    = a_op_r;
    entry_b.idx   = a_idx_r;
    entry_b.white = luma_b > ipmb_pkg::LUMA_LIMIT;
    entry_b.addr  = '0;
    entry_b.mask  = '0;
    if (a_op_r == ipmb_pkg::OP_WRITE) begin
      entry_b.addr = addr_b;
      entry_b.mask = ipmb_pkg::MASK_MSB >> a_sx_r[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      b_entry_r <= entry_b;
    end
  end

  assign q_push  = b_go;
  assign q_entry = b_entry_r;

endmodule

/* sv/ipmb_queue.sv */
// short fifo between the front and back ends
module ipmb_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ipmb_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output ipmb_pkg::entry_t head
);

  localparam int PTR_W = $clog2(ipmb_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(ipmb_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ipmb_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(ipmb_pkg::QUEUE_DEPTH - 1);

  ipmb_pkg::entry_t   slot_r [ipmb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full  = cnt_r == FULL_CNT;
  assign empty = cnt_r == '0;
  assign head  = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

/* sv/ipmb_back.sv */
// back end: palette table writes and reads, result register toward the output
module ipmb_back #(
  parameter int PALETTE_DEPTH = ipmb_pkg::PALETTE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  ipmb_pkg::entry_t              q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [ipmb_pkg::ADDR_W-1:0]   out_byte_address,
  output logic [ipmb_pkg::MASK_W-1:0]   out_bit_mask,
  output logic                          out_bit_value
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [PALETTE_DEPTH-1:0]        vld_r, vld_nxt;
  logic                            out_vld_r, out_vld_nxt;
  logic [1:0]                      out_op_r;
  logic [ipmb_pkg::ADDR_W-1:0]     out_addr_r;
  logic [ipmb_pkg::MASK_W-1:0]     out_mask_r;
  logic                            out_hit_r;
  logic                            o_free, tbl_we, tbl_re, tbl_q;
  logic [AW-1:0]                   tbl_addr;

  // pop the queue head whenever the result register can take it
  assign o_free   = !out_vld_r || !out_stall;
  assign q_pop    = !q_empty && o_free;
  assign tbl_addr = q_head.idx[AW-1:0];
  assign tbl_we   = q_pop && (q_head.op == ipmb_pkg::OP_LOAD);
  assign tbl_re   = q_pop && (q_head.op == ipmb_pkg::OP_WRITE);

  // black or white bit for each palette slot
  ipmb_ram #(
    .WIDTH (1),
    .DEPTH (PALETTE_DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_addr),
    .wdata (q_head.white),
    .re    (tbl_re),
    .raddr (tbl_addr),
    .rdata (tbl_q)
  );

  // per-slot written flags, a slot never loaded reads as black
  always_comb begin
    vld_nxt = vld_r;
    if (tbl_we) begin
      vld_nxt[tbl_addr] = 1'b1;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (q_pop) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_op_r   <= q_head.op;
      out_addr_r <= q_head.addr;
      out_mask_r <= q_head.mask;
      out_hit_r  <= tbl_re && vld_r[tbl_addr];
    end
  end

  always_comb begin
    case (out_op_r)
      ipmb_pkg::OP_WRITE: out_status = ipmb_pkg::STATUS_WRITE;
      ipmb_pkg::OP_ERROR: out_status = ipmb_pkg::STATUS_ERROR;
      default:            out_status = ipmb_pkg::STATUS_NONE;
    endcase
  end

  assign out_valid        = out_vld_r;
  assign out_byte_address = out_addr_r;
  assign out_bit_mask     = out_mask_r;
  assign out_bit_value    = out_hit_r && tbl_q;

endmodule

/* sv/indexed_pixel_to_mono_bitmap.sv */
// top level: configuration registers, front end, queue and back end
// path: an accepted transaction passes stage a, stage b, the queue and the result register
// throughput: one transaction per cycle while out_stall is low; two front stages, a 2-entry
//   queue and the result register with the palette table read keep every part busy
// reset: synchronous active-low rst_n clears pipeline, queue, raster counters and
//   palette written flags; configuration returns to its defaults
module indexed_pixel_to_mono_bitmap #(
  parameter int PALETTE_DEPTH = ipmb_pkg::PALETTE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ipmb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ipmb_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_mode,
  input  logic [ipmb_pkg::IDX_W-1:0]         in_color_index,
  input  logic [7:0]                         in_red,
  input  logic [7:0]                         in_green,
  input  logic [7:0]                         in_blue,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_status,
  output logic [ipmb_pkg::ADDR_W-1:0]        out_byte_address,
  output logic [ipmb_pkg::MASK_W-1:0]        out_bit_mask,
  output logic                               out_bit_value
);

`include "indexed_pixel_to_mono_bitmap_macros.svh"

  localparam logic [ipmb_pkg::COL_W-1:0] WIDTH_RST =
    ipmb_pkg::COL_W'(ipmb_pkg::SCREEN_WIDTH);
  localparam logic [ipmb_pkg::PITCH_W-1:0] PITCH_RST =
    ipmb_pkg::PITCH_W'(ipmb_pkg::SCREEN_WIDTH / 8);
  localparam logic [ipmb_pkg::PCNT_W-1:0] PCNT_RST = ipmb_pkg::PCNT_W'(PALETTE_DEPTH);

  ipmb_pkg::cfg_t    cfg_r, cfg_nxt;
  ipmb_pkg::entry_t  q_entry, q_head;
  logic              q_push, q_full, q_pop, q_empty;

  // configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        ipmb_pkg::REG_FRAME_LEFT:    cfg_nxt.frame_left = cfg_data;
        ipmb_pkg::REG_FRAME_TOP:     cfg_nxt.frame_top = cfg_data[ipmb_pkg::ROW_W-1:0];
        ipmb_pkg::REG_FRAME_WIDTH:   cfg_nxt.frame_width = cfg_data;
        ipmb_pkg::REG_LINE_PITCH:    cfg_nxt.line_pitch = cfg_data;
        ipmb_pkg::REG_PALETTE_COUNT: cfg_nxt.palette_count = cfg_data[ipmb_pkg::PCNT_W-1:0];
        ipmb_pkg::REG_TRANSP_EN:     cfg_nxt.transparent_enable = cfg_data[0];
        ipmb_pkg::REG_TRANSP_INDEX:  cfg_nxt.transparent_index = cfg_data[ipmb_pkg::IDX_W-1:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_left         <= '0;
      cfg_r.frame_top          <= '0;
      cfg_r.frame_width        <= WIDTH_RST;
      cfg_r.line_pitch         <= PITCH_RST;
      cfg_r.palette_count      <= PCNT_RST;
      cfg_r.transparent_enable <= 1'b0;
      cfg_r.transparent_index  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front end
  ipmb_front #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_color_index (in_color_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .q_push         (q_push),
    .q_entry        (q_entry),
    .q_full         (q_full)
  );

  // decoupling queue
  ipmb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  // back end
  ipmb_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_byte_address (out_byte_address),
    .out_bit_mask     (out_bit_mask),
    .out_bit_value    (out_bit_value)
  );

  // results that write nothing carry zero address, mask and value
  `IPMB_ASSERT_SAME(a_nowrite_zero, clk, rst_n,
    out_valid && (out_status != ipmb_pkg::STATUS_WRITE),
    (out_byte_address == '0) && (out_bit_mask == '0) && !out_bit_value)

  // a bit write names exactly one bit of its byte
  `IPMB_ASSERT_SAME(a_write_onehot, clk, rst_n,
    out_valid && (out_status == ipmb_pkg::STATUS_WRITE),
    $onehot(out_bit_mask))

  // an error popped from the queue shows up as an error result next cycle
  `IPMB_ASSERT_NEXT(a_error_passes, clk, rst_n,
    q_pop && (q_head.op == ipmb_pkg::OP_ERROR),
    out_valid && (out_status == ipmb_pkg::STATUS_ERROR))

endmodule
